@@ rtl/core/frtg_pkg.sv @@
// Package for the frame rate tier governor.
// Holds the tier type, the register indexes and the rate thresholds.
// No dependencies.
package frtg_pkg;

  // Quality tiers, highest first.
  typedef enum logic [1:0] {
    TIER_HIGH   = 2'd0,
    TIER_MID    = 2'd1,
    TIER_LOW    = 2'd2,
    TIER_BOTTOM = 2'd3
  } tier_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_TIER     = 2'd0,
    CFG_MONITOR_ENABLE = 2'd1
  } cfg_idx_t;

  // Tick bookkeeping.
  localparam int unsigned GRACE_W     = 3;
  localparam int unsigned GRACE_SAT   = 4;
  localparam int unsigned GRACE_LAST  = 3;
  localparam int unsigned SAMPLES_MAX = 2;

  // Rates in frames per second, WORST_MS_MAX in ms, the rest counts.
  localparam int unsigned HIGH_AVG      = 65;
  localparam int unsigned SAVER_AVG_LO  = 28;
  localparam int unsigned SAVER_AVG_HI  = 34;
  localparam int unsigned SAVER_FPS_HI  = 33;
  localparam int unsigned WORST_MS_MAX  = 45;
  localparam int unsigned RETURN_FPS    = 45;
  localparam int unsigned BASE_DEFAULT  = 60;
  localparam int unsigned BASE_SAVER    = 30;
  localparam int unsigned FLOOR_SAVER   = 22;
  localparam int unsigned FLOOR_NORMAL  = 40;
  localparam int unsigned DROP_LIMIT    = 3;
  localparam int unsigned DROP_RECOVER  = 2;
  localparam int unsigned SAVER_CONFIRM = 2;
  localparam int unsigned SAVER_SAT     = 255;

endpackage

@@ rtl/core/frame_rate_tier_governor.sv @@
// Frame rate tier governor, top level.
// Depends on frtg_pkg.
//
// Usage: each input beat on the in_ channel is one one-second tick carrying
// the measured frame rate and the worst frame interval of that second. Every
// tick produces exactly one result beat on the out_ channel with the tier,
// a downgrade flag, the baseline rate and whether the governor still reacts.
// A beat moves when valid is high and stall is low.
// The tick is captured in an input register; the governor state and result
// register update from it when the latter is free. Throughput is one tick
// per cycle when not stalled; a single short pass of counters and compares
// lets back-to-back ticks see each other's state. When the receiver stalls,
// the result register holds its beat and the input register still takes one
// more tick; in_stall rises once both are full. The cfg_ channel is always
// ready. Writing start_tier also loads the tier at once; the user must write
// registers only while no tick is in flight; the block does not enforce it.
// Synchronous reset (rst_n low) empties both registers, sets the tier to
// HIGH, enables monitoring and puts the baseline at 60 frames per second.
module frame_rate_tier_governor
  import frtg_pkg::*;
#(
  parameter int unsigned RATE_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Tick channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [RATE_BITS-1:0] in_frame_rate,
  input  logic [9:0]           in_worst_frame_ms,
  // Result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_tier_now,
  output logic                 out_downgraded,
  output logic [RATE_BITS-1:0] out_baseline_rate,
  output logic                 out_still_active,
  // Configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [1:0]           cfg_data
);

  localparam int unsigned RW = RATE_BITS;
  localparam int unsigned SW = RATE_BITS + 1;

  // Configuration and governor state.
  logic               mon_en_r;
  tier_t              tier_r, tier_nxt;
  logic [GRACE_W-1:0] grace_r, grace_nxt;
  logic [SW-1:0]      sum_r, sum_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               locked_r, locked_nxt;
  logic [RW-1:0]      base_r, base_nxt;
  logic [7:0]         saver_r, saver_nxt;
  logic [1:0]         drop_r, drop_nxt;

  // Pipeline registers.
  logic               s1_valid_r;
  logic [RW-1:0]      s1_fps_r;
  logic [9:0]         s1_ms_r;
  logic               out_valid_r;
  tier_t              out_tier_r;
  logic               out_down_r;
  logic [RW-1:0]      out_base_r;
  logic               out_active_r;

  // Working values of the tick update.
  logic               out_free;
  logic               advance;
  logic               active;
  logic               down;
  logic [RW-1:0]      avg;
  logic [SW:0]        sum_rnd;
  logic [SW:0]        thr_high, thr_lo, thr_hi;
  logic [2:0]         drop_w;
  logic [RW-1:0]      floor_rate;
  logic               cfg_write;

  // Handshake: the result register frees up when empty or taken.
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  assign active = mon_en_r && (tier_r == TIER_HIGH || tier_r == TIER_MID);

  // Average of one or two samples, rounded half up.
  assign sum_rnd  = {1'b0, sum_r} + (SW+1)'(1);
  assign avg      = (cnt_r == 2'd1) ? sum_r[RW-1:0] : sum_rnd[RW:1];
  assign thr_high = (cnt_r == 2'd1) ? (SW+1)'(HIGH_AVG)     : (SW+1)'(2 * HIGH_AVG);
  assign thr_lo   = (cnt_r == 2'd1) ? (SW+1)'(SAVER_AVG_LO) : (SW+1)'(2 * SAVER_AVG_LO);
  assign thr_hi   = (cnt_r == 2'd1) ? (SW+1)'(SAVER_AVG_HI) : (SW+1)'(2 * SAVER_AVG_HI);

  // Single-pass tick update of the governor state.
  always_comb begin
    grace_nxt  = grace_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    locked_nxt = locked_r;
    base_nxt   = base_r;
    saver_nxt  = saver_r;
    drop_w     = {1'b0, drop_r};
    tier_nxt   = tier_r;
    down       = 1'b0;
    floor_rate = RW'(FLOOR_NORMAL);
    if (advance && active) begin
      if (grace_r < GRACE_W'(GRACE_SAT)) begin
        grace_nxt = grace_r + GRACE_W'(1);
      end
      if (grace_nxt <= GRACE_W'(GRACE_LAST)) begin
        // Grace ticks: collect samples from ticks two and three.
        if (grace_nxt > GRACE_W'(1) && s1_fps_r != '0 && cnt_r < 2'(SAMPLES_MAX)) begin
          sum_nxt = sum_r + SW'(s1_fps_r);
          cnt_nxt = cnt_r + 2'd1;
        end
      end else begin
        // Lock the baseline once from the sample average.
        if (cnt_r != 2'd0 && !locked_r) begin
          if ({1'b0, sum_r} > thr_high) begin
            base_nxt = avg;
          end else if ({1'b0, sum_r} >= thr_lo && {1'b0, sum_r} <= thr_hi &&
                       s1_ms_r < 10'(WORST_MS_MAX)) begin
            base_nxt = RW'(BASE_SAVER);
          end else begin
            base_nxt = RW'(BASE_DEFAULT);
          end
          locked_nxt = 1'b1;
        end

        // Battery-saver detection and return.
        if (base_nxt >= RW'(BASE_DEFAULT) && s1_fps_r >= RW'(SAVER_AVG_LO) &&
            s1_fps_r <= RW'(SAVER_FPS_HI) && s1_ms_r < 10'(WORST_MS_MAX)) begin
          if (saver_r < 8'(SAVER_SAT)) begin
            saver_nxt = saver_r + 8'd1;
          end
          if (saver_nxt >= 8'(SAVER_CONFIRM)) begin
            base_nxt = RW'(BASE_SAVER);
            drop_w   = 3'd0;
          end
        end else if (base_nxt == RW'(BASE_SAVER) && s1_fps_r >= RW'(RETURN_FPS)) begin
          base_nxt  = (s1_fps_r > RW'(HIGH_AVG)) ? s1_fps_r : RW'(BASE_DEFAULT);
          drop_w    = 3'd0;
          saver_nxt = 8'd0;
        end else if (base_nxt >= RW'(BASE_DEFAULT)) begin
          if (saver_r != 8'd0) begin
            saver_nxt = saver_r - 8'd1;
          end
        end

        // Drop counter against the rate floor.
        floor_rate = (base_nxt == RW'(BASE_SAVER)) ? RW'(FLOOR_SAVER) : RW'(FLOOR_NORMAL);
        if (s1_fps_r < floor_rate) begin
          drop_w = drop_w + 3'd1;
        end else begin
          drop_w = (drop_w > 3'(DROP_RECOVER)) ? drop_w - 3'(DROP_RECOVER) : 3'd0;
        end
        if (drop_w >= 3'(DROP_LIMIT)) begin
          tier_nxt = (tier_r == TIER_HIGH) ? TIER_MID : TIER_LOW;
          down     = 1'b1;
          drop_w   = 3'd0;
        end
      end
    end
    drop_nxt = drop_w[1:0];
  end

  // Governor state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mon_en_r <= 1'b1;
      tier_r   <= TIER_HIGH;
      grace_r  <= '0;
      sum_r    <= '0;
      cnt_r    <= '0;
      locked_r <= 1'b0;
      base_r   <= RW'(BASE_DEFAULT);
      saver_r  <= '0;
      drop_r   <= '0;
    end else begin
      grace_r  <= grace_nxt;
      sum_r    <= sum_nxt;
      cnt_r    <= cnt_nxt;
      locked_r <= locked_nxt;
      base_r   <= base_nxt;
      saver_r  <= saver_nxt;
      drop_r   <= drop_nxt;
      // A start tier write loads the tier directly.
      if (cfg_write && cfg_index == CFG_START_TIER) begin
        tier_r <= tier_t'(cfg_data);
      end else begin
        tier_r <= tier_nxt;
      end
      if (cfg_write && cfg_index == CFG_MONITOR_ENABLE) begin
        mon_en_r <= cfg_data[0];
      end
    end
  end

  // Input register valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_fps_r <= in_frame_rate;
      s1_ms_r  <= in_worst_frame_ms;
    end
  end

  // Result register valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_tier_r   <= tier_nxt;
      out_down_r   <= down;
      out_base_r   <= base_nxt;
      out_active_r <= mon_en_r && (tier_nxt == TIER_HIGH || tier_nxt == TIER_MID);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tier_now      = out_tier_r;
  assign out_downgraded    = out_down_r;
  assign out_baseline_rate = out_base_r;
  assign out_still_active  = out_active_r;

endmodule

@@ rtl/core/frtg_checker.sv @@
// Port-level checker for the frame rate tier governor, with its bind.
// Depends on frtg_pkg and the frame_rate_tier_governor ports.
module frtg_checker
  import frtg_pkg::*;
#(
  parameter int unsigned RATE_BITS = 10
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [1:0]           out_tier_now,
  input logic                 out_downgraded,
  input logic [RATE_BITS-1:0] out_baseline_rate,
  input logic                 out_still_active
);

  // A result beat stays offered and unchanged while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tier_now) &&
      $stable(out_downgraded) && $stable(out_baseline_rate) && $stable(out_still_active))
    else $error("result beat dropped or changed under stall");

  // A downgrade always lands on MID or LOW.
  a_down_tier: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_downgraded |->
      (out_tier_now == TIER_MID || out_tier_now == TIER_LOW))
    else $error("downgrade to an impossible tier");

  // An active governor can only sit at HIGH or MID.
  a_active_tier: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_still_active |->
      (out_tier_now == TIER_HIGH || out_tier_now == TIER_MID))
    else $error("governor active at a frozen tier");

  // Reset leaves the result channel empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // With the result register empty, the tick channel is never stalled.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid |-> !in_stall)
    else $error("tick stalled with an empty result register");

endmodule

bind frame_rate_tier_governor frtg_checker #(.RATE_BITS(RATE_BITS)) u_frtg_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_tier_now      (out_tier_now),
  .out_downgraded    (out_downgraded),
  .out_baseline_rate (out_baseline_rate),
  .out_still_active  (out_still_active)
);

@@ sim/frame_rate_tier_governor_test.sv @@
// Self-checking testbench for the frame rate tier governor.
// Mirrors the tier, baseline and battery-saver state in a tracker class and checks
// every result beat in order; depends on frtg_pkg and frame_rate_tier_governor.
module frame_rate_tier_governor_test;
  import frtg_pkg::*;

  localparam int unsigned RATE_W       = 10;
  localparam int unsigned MS_W         = 10;
  localparam int unsigned RANDOM_TICKS = 1000;
  localparam int unsigned RUN_LIMIT    = 1_000_000;

  // Register indexes past the last register; writes to them are ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // Thresholds in frames per second or, where marked, ms; the last seven are counts.
  localparam int unsigned AVG_KEEP_ABOVE = 65;
  localparam int unsigned AVG_SAVER_LO   = 28;
  localparam int unsigned AVG_SAVER_HI   = 34;
  localparam int unsigned SAVER_RATE_LO  = 28;
  localparam int unsigned SAVER_RATE_HI  = 33;
  localparam int unsigned CALM_MS_LIMIT  = 45;  // worst frame time, ms
  localparam int unsigned WAKE_RATE      = 45;
  localparam int unsigned NORMAL_BASE    = 60;
  localparam int unsigned SAVER_BASE     = 30;
  localparam int unsigned SAVER_FLOOR    = 22;
  localparam int unsigned NORMAL_FLOOR   = 40;
  localparam int unsigned DROPS_TO_DOWN  = 3;
  localparam int unsigned DROP_FORGIVE   = 2;
  localparam int unsigned SAVER_HITS     = 2;
  localparam int unsigned SAVER_CAP      = 255;
  localparam int unsigned GRACE_CAP      = 4;
  localparam int unsigned GRACE_TICKS    = 3;
  localparam int unsigned SAMPLE_CAP     = 2;

  typedef enum {OPEN_HIGH_AVG, OPEN_SAVER_AVG, OPEN_PLAIN_AVG, OPEN_NO_SAMPLES,
                OPEN_ONE_SAMPLE} opening_t;
  typedef enum {TICK_STEADY, TICK_SAVER, TICK_WAKE, TICK_DROP, TICK_NOISE} tick_kind_t;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  typedef struct packed {
    tier_t             tier;
    logic              down;
    logic [RATE_W-1:0] base;
    logic              live;
  } tier_report_t;

  // Tracks the governor state and holds the reports still owed by the block.
  class tier_tracker;
    logic              monitor_on;
    logic [2:0]        grace;
    logic [10:0]       rate_sum;
    logic [1:0]        rate_samples;
    logic              base_locked;
    logic [RATE_W-1:0] base;
    logic [7:0]        saver_hits;
    logic [1:0]        drops;
    tier_t             tier;
    tier_report_t      due_reports[$];
    int                errors;

    function new();
      monitor_on   = 1'b1;
      grace        = '0;
      rate_sum     = '0;
      rate_samples = '0;
      base_locked  = 1'b0;
      base         = RATE_W'(NORMAL_BASE);
      saver_hits   = '0;
      drops        = '0;
      tier         = TIER_HIGH;
      errors       = 0;
    endfunction

    function bit is_live();
      return monitor_on && (tier == TIER_HIGH || tier == TIER_MID);
    endfunction

    // Writing the start tier loads the tier at once.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [1:0] data);
      if (idx == CFG_START_TIER) begin
        tier = tier_t'(data);
      end else if (idx == CFG_MONITOR_ENABLE) begin
        monitor_on = data[0];
      end
    endfunction

    function void take_tick(logic [RATE_W-1:0] fps, logic [MS_W-1:0] ms);
      tier_report_t rep;
      int unsigned  n;
      int unsigned  floor_fps;
      rep.down = 1'b0;
      if (is_live()) begin
        if (grace < GRACE_CAP) grace++;
        if (grace <= GRACE_TICKS) begin
          // Ticks two and three collect nonzero rates for the baseline.
          if (grace > 1 && fps != 0 && rate_samples < SAMPLE_CAP) begin
            rate_sum = rate_sum + 11'(fps);
            rate_samples++;
          end
        end else begin
          // The first tick after the grace ticks locks the baseline.
          if (rate_samples != 0 && !base_locked) begin
            n = rate_samples;
            if (rate_sum > AVG_KEEP_ABOVE * n) begin
              base = RATE_W'((rate_sum + n / 2) / n);
            end else if (rate_sum >= AVG_SAVER_LO * n && rate_sum <= AVG_SAVER_HI * n &&
                         ms < CALM_MS_LIMIT) begin
              base = RATE_W'(SAVER_BASE);
            end else begin
              base = RATE_W'(NORMAL_BASE);
            end
            base_locked = 1'b1;
          end

          // Battery-saver detection and the return from it.
          if (base >= NORMAL_BASE && fps >= SAVER_RATE_LO && fps <= SAVER_RATE_HI &&
              ms < CALM_MS_LIMIT) begin
            if (saver_hits < SAVER_CAP) saver_hits++;
            if (saver_hits >= SAVER_HITS) begin
              base  = RATE_W'(SAVER_BASE);
              drops = '0;
            end
          end else if (base == SAVER_BASE && fps >= WAKE_RATE) begin
            base       = (fps > AVG_KEEP_ABOVE) ? fps : RATE_W'(NORMAL_BASE);
            drops      = '0;
            saver_hits = '0;
          end else if (base >= NORMAL_BASE) begin
            if (saver_hits > 0) saver_hits--;
          end

          // Slow ticks pile up; fast ones forgive two at a time.
          floor_fps = (base == SAVER_BASE) ? SAVER_FLOOR : NORMAL_FLOOR;
          if (fps < floor_fps) begin
            drops++;
          end else begin
            drops = (drops > DROP_FORGIVE) ? drops - 2'(DROP_FORGIVE) : 2'd0;
          end
          if (drops >= DROPS_TO_DOWN) begin
            tier     = (tier == TIER_HIGH) ? TIER_MID : TIER_LOW;
            rep.down = 1'b1;
            drops    = '0;
          end
        end
      end
      rep.tier = tier;
      rep.base = base;
      rep.live = is_live();
      due_reports.insert(due_reports.size(), rep);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void match_result(logic [1:0] tier_v, logic down_v, logic [RATE_W-1:0] base_v,
                               logic live_v);
      tier_report_t want;
      if (due_reports.size() == 0) begin
        $display("%0t: result beat with no tick owed, expected none actual tier %0d base %0d",
                 $time, tier_v, base_v);
        errors++;
        return;
      end
      want = due_reports.pop_front();
      compare_field("tier_now", 16'(want.tier), 16'(tier_v));
      compare_field("downgraded", 16'(want.down), 16'(down_v));
      compare_field("baseline_rate", 16'(want.base), 16'(base_v));
      compare_field("still_active", 16'(want.live), 16'(live_v));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n             = 1'b0;
  logic                 in_valid          = 1'b0;
  logic                 in_stall;
  logic [RATE_W-1:0]    in_frame_rate     = '0;
  logic [MS_W-1:0]      in_worst_frame_ms = '0;
  logic                 out_valid;
  logic                 out_stall         = 1'b0;
  logic [1:0]           out_tier_now;
  logic                 out_downgraded;
  logic [RATE_W-1:0]    out_baseline_rate;
  logic                 out_still_active;
  logic                 cfg_valid         = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index         = '0;
  logic [1:0]           cfg_data          = '0;

  tier_tracker tracker = new();
  tick_kind_t  kind = TICK_STEADY;
  int unsigned streak_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_left = 0;

  frame_rate_tier_governor #(
    .RATE_BITS(RATE_W)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_frame_rate    (in_frame_rate),
    .in_worst_frame_ms(in_worst_frame_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tier_now     (out_tier_now),
    .out_downgraded   (out_downgraded),
    .out_baseline_rate(out_baseline_rate),
    .out_still_active (out_still_active),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: checks each accepted beat and stalls in modes that change now and then.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.match_result(out_tier_now, out_downgraded, out_baseline_rate, out_still_active);
    end
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      stall_left = $urandom_range(4, 40);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_LIGHT: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_stall <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  // Presents one tick and returns on the edge that accepts it.
  task automatic send_tick(logic [RATE_W-1:0] fps, logic [MS_W-1:0] ms);
    in_valid          <= 1'b1;
    in_frame_rate     <= fps;
    in_worst_frame_ms <= ms;
    do @(posedge clk); while (in_stall);
    tracker.take_tick(fps, ms);
  endtask

  // Stops sending and waits until every owed result beat has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.due_reports.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Ticks come in streaks of one kind so that saver and drop sequences form.
  task automatic pick_tick(output logic [RATE_W-1:0] fps, output logic [MS_W-1:0] ms);
    int unsigned roll;
    if (streak_left == 0) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) kind = TICK_STEADY;
      else if (roll < 55) kind = TICK_SAVER;
      else if (roll < 68) kind = TICK_WAKE;
      else if (roll < 80) kind = TICK_DROP;
      else kind = TICK_NOISE;
      streak_left = $urandom_range(1, 4);
    end
    streak_left--;
    ms = MS_W'($urandom_range(0, 1023));
    case (kind)
      TICK_STEADY: begin
        fps = RATE_W'($urandom_range(40, 130));
      end
      TICK_SAVER: begin
        // The worst frame time straddles the calm limit.
        fps = RATE_W'($urandom_range(SAVER_RATE_LO, SAVER_RATE_HI));
        ms  = MS_W'($urandom_range(0, 50));
      end
      TICK_WAKE: begin
        fps = $urandom_range(0, 1) ? RATE_W'($urandom_range(45, 65))
                                   : RATE_W'($urandom_range(66, 1023));
      end
      TICK_DROP: begin
        fps = RATE_W'($urandom_range(0, 39));
      end
      default: begin
        fps = RATE_W'($urandom_range(0, 1023));
      end
    endcase
  endtask

  // Sends a run of ticks in bursts of random length with random gaps between them.
  task automatic run_phase(int unsigned count);
    logic [RATE_W-1:0] fps;
    logic [MS_W-1:0]   ms;
    int unsigned       burst;
    burst = $urandom_range(1, 8);
    for (int unsigned i = 0; i < count; i++) begin
      pick_tick(fps, ms);
      send_tick(fps, ms);
      burst--;
      if (burst == 0 && i + 1 < count) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      end
    end
  endtask

  // New settings for a phase; mostly an active governor at HIGH or MID.
  task automatic shuffle_config();
    int unsigned roll;
    tier_t       start;
    roll = $urandom_range(0, 9);
    if (roll < 5) start = TIER_HIGH;
    else if (roll < 8) start = TIER_MID;
    else if (roll == 8) start = TIER_LOW;
    else start = TIER_BOTTOM;
    write_reg(CFG_START_TIER, start);
    write_reg(CFG_MONITOR_ENABLE, {1'($urandom_range(0, 1)), 1'($urandom_range(0, 6) != 0)});
    if ($urandom_range(0, 7) == 0) begin
      write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 2'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    opening_t          opening;
    logic [RATE_W-1:0] first_fps;
    logic [RATE_W-1:0] second_fps;
    int unsigned       sent;
    int unsigned       phase_len;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Grace ticks: the first is never sampled, the next two feed the average
    // if nonzero, and the fourth locks the baseline in one of its ways if either did.
    opening = opening_t'($urandom_range(0, 4));
    case (opening)
      OPEN_HIGH_AVG: begin
        first_fps  = RATE_W'($urandom_range(66, 1023));
        second_fps = RATE_W'($urandom_range(66, 1023));
      end
      OPEN_SAVER_AVG: begin
        first_fps  = RATE_W'($urandom_range(AVG_SAVER_LO, AVG_SAVER_HI));
        second_fps = RATE_W'($urandom_range(AVG_SAVER_LO, AVG_SAVER_HI));
      end
      OPEN_PLAIN_AVG: begin
        first_fps  = RATE_W'($urandom_range(35, 65));
        second_fps = RATE_W'($urandom_range(35, 65));
      end
      OPEN_NO_SAMPLES: begin
        first_fps  = '0;
        second_fps = '0;
      end
      default: begin
        first_fps  = '0;
        second_fps = RATE_W'($urandom_range(1, 1023));
      end
    endcase
    send_tick(10'd1023, 10'd1023);
    send_tick(first_fps, MS_W'($urandom_range(0, 1023)));
    send_tick(second_fps, MS_W'($urandom_range(0, 1023)));
    send_tick(RATE_W'($urandom_range(40, 1023)), MS_W'($urandom_range(0, 90)));

    // Both fields at their extremes.
    send_tick(10'd0, 10'd0);
    send_tick(10'd1023, 10'd1023);
    send_tick(10'd1023, 10'd0);

    // Saver entry: the first tick sits on the calm limit, the next two are calm.
    send_tick(10'd33, 10'd45);
    send_tick(10'd28, 10'd0);
    send_tick(10'd33, 10'd44);

    // A fast tick leaves saver mode at its own rate, then saver mode again.
    send_tick(10'd900, 10'd512);
    send_tick(10'd30, 10'd10);
    send_tick(10'd31, 10'd20);

    // Leaving saver mode at exactly the wake rate gives the default baseline.
    send_tick(10'd45, 10'd1023);

    // Three slow ticks step HIGH to MID, three more step MID to LOW.
    send_tick(10'd21, 10'd0);
    send_tick(10'd0, 10'd7);
    send_tick(10'd39, 10'd3);
    send_tick(10'd12, 10'd0);
    send_tick(10'd5, 10'd0);
    send_tick(10'd1, 10'd0);

    // Frozen at LOW.
    send_tick(10'd500, 10'd500);

    // Disabled governor ignores slow ticks even at HIGH.
    drain();
    write_reg(CFG_MONITOR_ENABLE, 2'b00);
    write_reg(CFG_START_TIER, TIER_HIGH);
    send_tick(10'd10, 10'd10);
    send_tick(10'd0, 10'd0);

    // Re-enable; the spare indexes must change nothing.
    drain();
    write_reg(CFG_MONITOR_ENABLE, 2'b11);
    write_reg(CFG_SPARE_LO, 2'b00);
    write_reg(CFG_SPARE_HI, 2'b11);
    send_tick(10'd60, 10'd5);

    // Frozen at the bottom tier, then resumed from MID.
    drain();
    write_reg(CFG_START_TIER, TIER_BOTTOM);
    send_tick(10'd0, 10'd0);
    drain();
    write_reg(CFG_START_TIER, TIER_MID);
    send_tick(10'd1023, 10'd1023);

    // Random phases; each starts from an idle block with fresh settings.
    sent = 0;
    while (sent < RANDOM_TICKS) begin
      drain();
      shuffle_config();
      phase_len = $urandom_range(20, 70);
      run_phase(phase_len);
      sent += phase_len;
    end

    drain();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("frame_rate_tier_governor_test: done, clean");
    end else begin
      $display("frame_rate_tier_governor_test: done, errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(RUN_LIMIT);
    $display("frame_rate_tier_governor_test: done, errors");
    $finish;
  end

endmodule

@@ frame_rate_tier_governor.f @@
rtl/core/frtg_pkg.sv
rtl/core/frame_rate_tier_governor.sv
rtl/core/frtg_checker.sv
sim/frame_rate_tier_governor_test.sv
